// File: rtl/ttsm_pkg.sv
// Shared types and constants for the touch-to-thumbstick mapper.
package ttsm_pkg;

  // Shared iterative unit sizing
  localparam int RemW  = 32;  // partial remainder
  localparam int SrcW  = 58;  // operand bits shifted in from the top
  localparam int QuoW  = 29;  // quotient / root
  localparam int StepW = 5;

  localparam logic [StepW-1:0] StepsAy   = StepW'(28);
  localparam logic [StepW-1:0] StepsSqrt = StepW'(29);
  localparam logic [StepW-1:0] StepsQ16  = StepW'(16);

  localparam int MulW = 28;
  localparam int ProdW = 2 * MulW;

  localparam logic [15:0] ThreshQ15 = 16'd3277;
  localparam logic [15:0] OneQ15    = 16'd32768;

  localparam logic [1:0] KEY_UP      = 2'd0;
  localparam logic [1:0] KEY_PRESSED = 2'd1;

  localparam logic [1:0] MODE_AREA  = 2'd0;
  localparam logic [1:0] MODE_ACT   = 2'd1;
  localparam logic [1:0] MODE_SWIPE = 2'd2;

  typedef enum logic [2:0] {
    CFG_CENTER_MODE = 3'd0,
    CFG_AREA_CX     = 3'd1,
    CFG_AREA_CY     = 3'd2,
    CFG_RADIUS      = 3'd3,
    CFG_ASPECT      = 3'd4,
    CFG_MAX_AXIS    = 3'd5,
    CFG_ENABLE      = 3'd6
  } cfg_idx_e;

  // Request to the shared divide / square root unit
  typedef struct packed {
    logic             start;
    logic             is_sqrt;
    logic [StepW-1:0] steps;
    logic [RemW-1:0]  rem;
    logic [SrcW-1:0]  src;
    logic [QuoW-1:0]  divisor;
  } iter_req_t;

endpackage

// File: rtl/ttsm_mul.sv
// Registered unsigned multiplier shared by all product steps.
module ttsm_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ttsm_pkg::MulW-1:0]   a_i,
  input  logic [ttsm_pkg::MulW-1:0]   b_i,
  output logic [ttsm_pkg::ProdW-1:0]  p_o
);
  import ttsm_pkg::*;

  logic [ProdW-1:0] p_q;

  // product holds while not enabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= ProdW'(a_i) * ProdW'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// File: rtl/ttsm_iter.sv
// Shared restoring divide / square root unit, one quotient or root bit per cycle.
module ttsm_iter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ttsm_pkg::iter_req_t        req_i,
  output logic                       busy_o,
  output logic [ttsm_pkg::QuoW-1:0]  quo_o
);
  import ttsm_pkg::*;

  logic             busy_q;
  logic [StepW-1:0] cnt_q;
  logic             sqrt_q;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [SrcW-1:0]  src_q;
  logic [QuoW-1:0]  quo_q;
  logic [QuoW-1:0]  div_q;
  logic [RemW-1:0]  rsh, trial;
  logic [RemW:0]    diff;
  logic             ge;

  always_comb begin
    if (sqrt_q) begin
      rsh   = {rem_q[RemW-3:0], src_q[SrcW-1 -: 2]};
      trial = {1'b0, quo_q, 2'b01};
    end else begin
      rsh   = {rem_q[RemW-2:0], src_q[SrcW-1]};
      trial = {3'b000, div_q};
    end
    diff  = {1'b0, rsh} - {1'b0, trial};
    ge    = ~diff[RemW];
    rem_d = ge ? diff[RemW-1:0] : rsh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q <= req_i.is_sqrt;
      rem_q  <= req_i.rem;
      src_q  <= req_i.src;
      div_q  <= req_i.divisor;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      src_q <= sqrt_q ? {src_q[SrcW-3:0], 2'b00} : {src_q[SrcW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/touch_to_thumbstick_mapper_top.sv
// Top level of the touch-to-thumbstick mapper: config, sequencer, output register.
//
// Channel | Dir | Handshake                     | Payload
// --------+-----+-------------------------------+---------------------------------------
// s_axis  | in  | s_axis_tvalid_i/s_axis_tready_o | tuser key_state, tdata x, y, frame time
// m_axis  | out | m_axis_tvalid_o/m_axis_tready_i | tuser is_active, tdata 5 Q1.15 values
// cfg     | in  | cfg_we_i (no back-pressure)    | cfg_idx_i register, cfg_data_i value
//
// In an active frame (after the blend states in swipe mode) the shared divide / sqrt
// unit runs 28 steps for the aspect divide, 29 for the length root and 3 x 16 for
// strength and the two direction quotients (skipped for a zero length), one bit per cycle.
// An up or disabled frame goes straight from idle to done. Input ready only in the idle state.
// The output register holds a finished beat while the sequencer starts the next
// frame; the sequencer stalls only when a second result is done before the first
// is taken. Reset is asynchronous, active low; no clearing pass is needed.
module touch_to_thumbstick_mapper_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input frames
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [15:0] touch_x, [31:16] touch_y, [47:32] frame_time
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] key_state
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [15:0] left, [31:16] right, [47:32] up,
                                        // [63:48] down, [79:64] strength
  output logic        m_axis_tuser_o    // [0] is_active
);
  import ttsm_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_BLX    = 18'h00002,  // blend: x product
    S_BLY    = 18'h00004,  // blend: update cx, y product
    S_BLW    = 18'h00008,  // blend: update cy
    S_CENTER = 18'h00010,  // latch touch, press handling
    S_DIFF   = 18'h00020,  // deltas, start aspect divide, ax^2
    S_AYDIV  = 18'h00040,
    S_AYSQ   = 18'h00080,
    S_SQRT0  = 18'h00100,
    S_SQRTW  = 18'h00200,
    S_STR0   = 18'h00400,
    S_STRW   = 18'h00800,
    S_VX0    = 18'h01000,
    S_VX1    = 18'h02000,
    S_VXW    = 18'h04000,
    S_VY1    = 18'h08000,
    S_VYW    = 18'h10000,
    S_DONE   = 18'h20000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [1:0]  mode_q;
  logic [15:0] acx_q, acy_q, rad_q, asp_q;
  logic        max_q, en_q;

  // persistent stick state
  logic [15:0] cx_q, cy_q, ltx_q, lty_q;

  // current frame and intermediates
  logic [1:0]      ks_q;
  logic [15:0]     tx_q, ty_q, ft_q;
  logic            active_q;
  logic [15:0]     ax_q;
  logic [27:0]     ay_q;
  logic            xneg_q, yneg_q;
  logic [56:0]     sq_q;
  logic [QuoW-1:0] len_q;
  logic [15:0]     str_q, vx_q, vy_q;

  // output register
  logic        m_valid_q;
  logic        m_user_q;
  logic [79:0] m_data_q;

  // shared units
  logic [MulW-1:0]  mul_a, mul_b;
  logic             mul_en;
  logic [ProdW-1:0] prod;
  iter_req_t        req;
  logic             iter_busy;
  logic [QuoW-1:0]  quo;

  logic s_fire, out_load;

  // ---------------------------------------------------------------------------
  // Config writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_AREA;
      acx_q  <= '0;
      acy_q  <= '0;
      rad_q  <= 16'd1;
      asp_q  <= 16'd4096;
      max_q  <= 1'b0;
      en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_MODE: mode_q <= cfg_data_i[1:0];
        CFG_AREA_CX:     acx_q  <= cfg_data_i;
        CFG_AREA_CY:     acy_q  <= cfg_data_i;
        CFG_RADIUS:      rad_q  <= cfg_data_i;
        CFG_ASPECT:      asp_q  <= cfg_data_i;
        CFG_MAX_AXIS:    max_q  <= cfg_data_i[0];
        CFG_ENABLE:      en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // zero radius / aspect act as 1
  logic [15:0] rad_eff, asp_eff;
  assign rad_eff = (rad_q == 16'd0) ? 16'd1 : rad_q;
  assign asp_eff = (asp_q == 16'd0) ? 16'd1 : asp_q;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  // swipe follow rate t = min(1.0, 4*dt) in Q16
  logic [17:0] ft4;
  logic [16:0] t_blend;
  assign ft4     = {ft_q, 2'b00};
  assign t_blend = (ft4 > 18'd65536) ? 17'h10000 : ft4[16:0];

  logic        bx_neg, by_neg;
  logic [15:0] bx_mag, by_mag;
  assign bx_neg = ltx_q < cx_q;
  assign by_neg = lty_q < cy_q;
  assign bx_mag = bx_neg ? (cx_q - ltx_q) : (ltx_q - cx_q);
  assign by_mag = by_neg ? (cy_q - lty_q) : (lty_q - cy_q);

  // c + floor((d*t + 32768) / 65536), product given as magnitude plus sign
  function automatic logic [15:0] blend_f(input logic [15:0] c, input logic neg,
                                          input logic [31:0] p);
    logic signed [34:0] q;
    q = neg ? (35'sd32768 - $signed({3'b000, p})) : ($signed({3'b000, p}) + 35'sd32768);
    return c + q[31:16];
  endfunction

  // vector from center to touch (center already updated)
  logic        dx_neg, dy_neg;
  logic [15:0] ax_c, ay_raw;
  logic [28:0] ay_num;
  assign dx_neg = tx_q < cx_q;
  assign dy_neg = ty_q < cy_q;
  assign ax_c   = dx_neg ? (cx_q - tx_q) : (tx_q - cx_q);
  assign ay_raw = dy_neg ? (cy_q - ty_q) : (ty_q - cy_q);
  assign ay_num = {1'b0, ay_raw, 12'h000} + {14'd0, asp_eff[15:1]};

  logic [15:0] len_min;
  logic [56:0] sq_sum;
  assign len_min = (len_q < {13'd0, rad_eff}) ? len_q[15:0] : rad_eff;
  assign sq_sum  = sq_q + {1'b0, prod};

  // ---------------------------------------------------------------------------
  // Shared multiplier operands
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_BLX: begin
        mul_a = {12'd0, bx_mag};
        mul_b = {11'd0, t_blend};
      end
      S_BLY: begin
        mul_a = {12'd0, by_mag};
        mul_b = {11'd0, t_blend};
      end
      S_DIFF: begin
        mul_a = {12'd0, ax_c};
        mul_b = {12'd0, ax_c};
      end
      S_AYSQ: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      S_VX0: begin
        mul_a = {12'd0, ax_q};
        mul_b = {12'd0, str_q};
      end
      S_VX1: begin
        mul_a = ay_q;
        mul_b = {12'd0, str_q};
      end
      default: mul_en = 1'b0;
    endcase
  end

  ttsm_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // ---------------------------------------------------------------------------
  // Shared divide / sqrt requests
  // ---------------------------------------------------------------------------
  always_comb begin
    req         = '0;
    req.divisor = {QuoW{1'b0}};
    unique case (state_q)
      S_DIFF: begin   // ay * 4096 / aspect, rounded
        req.start   = 1'b1;
        req.steps   = StepsAy;
        req.rem     = {31'd0, ay_num[28]};
        req.src     = {ay_num[27:0], 30'd0};
        req.divisor = {13'd0, asp_eff};
      end
      S_SQRT0: begin  // len = isqrt(ax^2 + ay^2)
        req.start   = 1'b1;
        req.is_sqrt = 1'b1;
        req.steps   = StepsSqrt;
        req.src     = {1'b0, sq_sum};
      end
      S_STR0: begin   // min(len, r) * 32768 / r
        req.start   = 1'b1;
        req.steps   = StepsQ16;
        req.rem     = {17'd0, len_min[15:1]};
        req.src     = {len_min[0], 57'd0};
        req.divisor = {13'd0, rad_eff};
      end
      S_VX1, S_VY1: begin  // component * strength / len
        req.start   = 1'b1;
        req.steps   = StepsQ16;
        req.rem     = {3'd0, prod[44:16]};
        req.src     = {prod[15:0], 42'd0};
        req.divisor = len_q;
      end
      default: ;
    endcase
  end

  ttsm_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .busy_o (iter_busy),
    .quo_o  (quo)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_load        = (state_q == S_DONE) & (~m_valid_q | m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (!en_q || s_axis_tuser_i == KEY_UP) begin
            state_d = S_DONE;
          end else if (mode_q == MODE_SWIPE) begin
            state_d = S_BLX;
          end else begin
            state_d = S_CENTER;
          end
        end
      end
      S_BLX:    state_d = S_BLY;
      S_BLY:    state_d = S_BLW;
      S_BLW:    state_d = S_CENTER;
      S_CENTER: state_d = S_DIFF;
      S_DIFF:   state_d = S_AYDIV;
      S_AYDIV:  if (!iter_busy) state_d = S_AYSQ;
      S_AYSQ:   state_d = S_SQRT0;
      S_SQRT0:  state_d = S_SQRTW;
      S_SQRTW:  if (!iter_busy) state_d = S_STR0;
      S_STR0:   state_d = S_STRW;
      S_STRW: begin
        if (!iter_busy) begin
          state_d = (len_q == '0) ? S_DONE : S_VX0;
        end
      end
      S_VX0:    state_d = S_VX1;
      S_VX1:    state_d = S_VXW;
      S_VXW:    if (!iter_busy) state_d = S_VY1;
      S_VY1:    state_d = S_VYW;
      S_VYW:    if (!iter_busy) state_d = S_DONE;
      S_DONE:   if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // persistent stick state: swipe blend, touch latch, press
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      ltx_q <= '0;
      lty_q <= '0;
    end else begin
      if (state_q == S_BLY) begin
        cx_q <= blend_f(cx_q, bx_neg, prod[31:0]);
      end
      if (state_q == S_BLW) begin
        cy_q <= blend_f(cy_q, by_neg, prod[31:0]);
      end
      if (state_q == S_CENTER) begin
        ltx_q <= tx_q;
        lty_q <= ty_q;
        if (ks_q == KEY_PRESSED) begin
          if (mode_q == MODE_ACT || mode_q == MODE_SWIPE) begin
            cx_q <= tx_q;
            cy_q <= ty_q;
          end else begin
            cx_q <= acx_q;
            cy_q <= acy_q;
          end
        end
      end
    end
  end

  // frame datapath registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      ks_q     <= s_axis_tuser_i;
      tx_q     <= s_axis_tdata_i[15:0];
      ty_q     <= s_axis_tdata_i[31:16];
      ft_q     <= s_axis_tdata_i[47:32];
      active_q <= en_q & (s_axis_tuser_i != KEY_UP);
    end
    if (state_q == S_DIFF) begin
      ax_q   <= ax_c;
      xneg_q <= dx_neg;
      yneg_q <= dy_neg;
    end
    if (state_q == S_AYDIV && !iter_busy) begin
      ay_q <= quo[27:0];
    end
    if (state_q == S_AYSQ) begin
      sq_q <= {1'b0, prod};
    end
    if (state_q == S_SQRTW && !iter_busy) begin
      len_q <= quo;
    end
    if (state_q == S_STRW && !iter_busy) begin
      str_q <= quo[15:0];
      vx_q  <= '0;
      vy_q  <= '0;
    end
    if (state_q == S_VXW && !iter_busy) begin
      vx_q <= quo[15:0];
    end
    if (state_q == S_VYW && !iter_busy) begin
      vy_q <= quo[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Result assembly and output register
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] thresh_f(input logic [15:0] v);
    return (v < ThreshQ15) ? 16'd0 : v;
  endfunction

  logic [15:0] vl, vr, vu, vd, vs;
  logic        x_wins;
  assign x_wins = {12'd0, ax_q} >= ay_q;

  always_comb begin
    vl = '0;
    vr = '0;
    vu = '0;
    vd = '0;
    vs = '0;
    if (active_q) begin
      vs = str_q;
      if (max_q) begin
        // strongest axis only; ties go to x
        if (x_wins) begin
          if (xneg_q) vl = vx_q; else vr = vx_q;
        end else begin
          if (yneg_q) vu = vy_q; else vd = vy_q;
        end
      end else begin
        if (xneg_q) vl = vx_q; else vr = vx_q;
        if (yneg_q) vu = vy_q; else vd = vy_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_user_q <= active_q;
      m_data_q <= {vs, thresh_f(vd), thresh_f(vu), thresh_f(vr), thresh_f(vl)};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tdata_o  = m_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the shared unit never runs while a new frame can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_busy |-> !s_axis_tready_o)
    else $error("divide/sqrt unit busy while input ready");

  // an inactive beat carries all-zero values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("inactive beat with nonzero values");

  // strength never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[79:64] <= OneQ15))
    else $error("strength above 1.0");

  // a nonzero direction value is at or above the dead zone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tdata_o[15:0] == '0 || m_axis_tdata_o[15:0] >= ThreshQ15) &&
       (m_axis_tdata_o[31:16] == '0 || m_axis_tdata_o[31:16] >= ThreshQ15) &&
       (m_axis_tdata_o[47:32] == '0 || m_axis_tdata_o[47:32] >= ThreshQ15) &&
       (m_axis_tdata_o[63:48] == '0 || m_axis_tdata_o[63:48] >= ThreshQ15)))
    else $error("direction value inside dead zone");

endmodule

// File: tb/tb_top.sv
// Self-checking bench for the touch-to-thumbstick mapper: directed and random frames.
module tb_top;
  import ttsm_pkg::*;

  // Key states with no package name; up and pressed come from the package.
  localparam logic [1:0] KEY_HELD     = 2'd2;
  localparam logic [1:0] KEY_RELEASED = 2'd3;
  // Unused center mode code, must act like the area center.
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  localparam int QuietLimit   = 2000;  // cycles with no beat on either side
  localparam int DrainCycles  = 150;   // idle wait after the last frame settles
  localparam int RandomFrames = 1250;  // random part stops once this many frames in total have been queued
  localparam int PhaseFrames  = 125;   // active frames aimed for per config setting

  // One touch frame, packed as the s-side tdata is, plus the key state.
  typedef struct packed {
    logic [1:0]  key;
    logic [15:0] ftime;
    logic [15:0] y;
    logic [15:0] x;
  } frame_t;

  // One stick result, packed as {tuser, tdata} on the m-side.
  typedef struct packed {
    logic        active;
    logic [15:0] strength;
    logic [15:0] down_v;
    logic [15:0] up_v;
    logic [15:0] right_v;
    logic [15:0] left_v;
  } stick_out_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  cfg_idx_e    cfg_idx   = CFG_CENTER_MODE;
  logic [15:0] cfg_data  = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata  = '0;
  logic [1:0]  in_tuser  = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        out_tuser;

  // Bench copy of the config registers, reset values.
  logic [1:0]  cfg_mode      = MODE_AREA;
  logic [15:0] area_x        = '0;
  logic [15:0] area_y        = '0;
  logic [15:0] radius_reg    = 16'd1;
  logic [15:0] aspect_reg    = 16'd4096;
  logic        max_axis_only = 1'b0;
  logic        stick_on      = 1'b1;

  // Bench copy of the stick state.
  logic [15:0] ctr_x = '0, ctr_y = '0, prev_x = '0, prev_y = '0;

  frame_t     pending_frames[$];
  stick_out_t expected_sticks[$];
  frame_t     cur_frame;
  stick_out_t seen_beat, want_beat;

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  int  busy_frames    = 0;   // frames that make the block do real work
  int  frames_pushed  = 0;
  bit  burst_mode     = 1'b0; // no idling on either side while set

  touch_to_thumbstick_mapper_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_tvalid),
    .s_axis_tready_o (in_tready),
    .s_axis_tdata_i  (in_tdata),   // [15:0] x, [31:16] y, [47:32] frame time
    .s_axis_tuser_i  (in_tuser),   // [1:0] key state
    .m_axis_tvalid_o (out_tvalid),
    .m_axis_tready_i (out_tready),
    .m_axis_tdata_o  (out_tdata),  // [15:0] left, right, up, down, [79:64] strength
    .m_axis_tuser_o  (out_tuser)   // [0] is_active
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bitwise integer square root, rounded down.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned rem_v, root, bitv;
    rem_v = v;
    root  = 0;
    bitv  = 64'h1 << 62;
    while (bitv > rem_v) bitv >>= 2;
    while (bitv != 0) begin
      if (rem_v >= root + bitv) begin
        rem_v -= root + bitv;
        root   = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Swipe follow: c moves toward tgt by (tgt - c) * t / 2^16, round half up.
  // Arithmetic shift gives the floor for negative steps as well.
  function automatic logic [15:0] swipe_follow(input logic [15:0] c, input logic [15:0] tgt,
                                               input longint t);
    longint q;
    q = (longint'(tgt) - longint'(c)) * t + 32768;
    return 16'(longint'(c) + (q >>> 16));
  endfunction

  // Direction values under 0.1 read as zero.
  function automatic logic [15:0] dead_zone(input longint unsigned v);
    return (v < ThreshQ15) ? 16'd0 : v[15:0];
  endfunction

  function automatic longint unsigned aspect_ratio_or_one();
    return (aspect_reg == 0) ? 1 : aspect_reg;
  endfunction

  // Expected stick output for one accepted frame; updates center and last touch.
  function automatic stick_out_t map_touch_frame(input frame_t f);
    stick_out_t      o;
    longint unsigned rad, asp, ax, ay, len, str, vx, vy;
    longint          dx, dy, t;
    o   = '0;
    rad = (radius_reg == 0) ? 1 : radius_reg;
    asp = (aspect_ratio_or_one());
    // up frames and a disabled stick leave everything alone
    if (!stick_on || f.key == KEY_UP) return o;

    if (cfg_mode == MODE_SWIPE) begin
      t = longint'(f.ftime) * 4;
      if (t > 65536) t = 65536;
      ctr_x = swipe_follow(ctr_x, prev_x, t);
      ctr_y = swipe_follow(ctr_y, prev_y, t);
    end
    prev_x = f.x;
    prev_y = f.y;
    if (f.key == KEY_PRESSED) begin
      if (cfg_mode == MODE_ACT || cfg_mode == MODE_SWIPE) begin
        ctr_x = f.x;
        ctr_y = f.y;
      end else begin
        ctr_x = area_x;
        ctr_y = area_y;
      end
    end

    dx  = longint'(f.x) - longint'(ctr_x);
    dy  = longint'(f.y) - longint'(ctr_y);
    ax  = (dx < 0) ? -dx : dx;
    ay  = (dy < 0) ? -dy : dy;
    ay  = (ay * 4096 + (asp >> 1)) / asp;  // y over aspect, Q4.12 divisor
    len = root_floor(ax * ax + ay * ay);
    str = ((len < rad) ? len : rad) * OneQ15 / rad;

    if (len != 0) begin
      vx = ax * str / len;
      vy = ay * str / len;
      if (max_axis_only) begin
        // ties go to x; sign picks the side
        if (ax >= ay) begin
          if (dx < 0) o.left_v = dead_zone(vx);
          else        o.right_v = dead_zone(vx);
        end else begin
          if (dy < 0) o.up_v = dead_zone(vy);
          else        o.down_v = dead_zone(vy);
        end
      end else begin
        if (dx < 0) o.left_v = dead_zone(vx);
        else        o.right_v = dead_zone(vx);
        if (dy < 0) o.up_v = dead_zone(vy);
        else        o.down_v = dead_zone(vy);
      end
    end
    o.active   = 1'b1;
    o.strength = str[15:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued frames, predicts at each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) expected_sticks.push_back(map_touch_frame(cur_frame));
      if (!in_tvalid || in_tready) begin
        // about 29 of 100 slots stay empty outside burst stretches
        if (pending_frames.size() != 0 && (burst_mode || $urandom_range(0, 99) >= 29)) begin
          cur_frame  = pending_frames.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_frame.ftime, cur_frame.y, cur_frame.x};
          in_tuser  <= cur_frame.key;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, checks each result beat in order
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_beat = stick_out_t'({out_tuser, out_tdata});
        if (expected_sticks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("%0t: result beat with nothing expected: act=%0d l=%0d r=%0d ",
                   $realtime, seen_beat.active, seen_beat.left_v, seen_beat.right_v);
            $display("u=%0d d=%0d s=%0d", seen_beat.up_v, seen_beat.down_v,
                     seen_beat.strength);
          end
        end else begin
          want_beat = expected_sticks.pop_front();
          if (want_beat != seen_beat) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $write("%0t: stick beat differs, exp act=%0d l=%0d r=%0d u=%0d d=%0d s=%0d, ",
                     $realtime, want_beat.active, want_beat.left_v, want_beat.right_v,
                     want_beat.up_v, want_beat.down_v, want_beat.strength);
              $display("got act=%0d l=%0d r=%0d u=%0d d=%0d s=%0d", seen_beat.active,
                       seen_beat.left_v, seen_beat.right_v, seen_beat.up_v,
                       seen_beat.down_v, seen_beat.strength);
            end
          end
        end
      end
      out_tready <= burst_mode || ($urandom_range(0, 99) >= 29);
    end
  end

  // Watchdog: too long with no beat on either side means the block is stuck.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_frame(input logic [1:0] key, input int x, input int y, input int ft);
    frame_t f;
    f.key   = key;
    f.x     = x[15:0];
    f.y     = y[15:0];
    f.ftime = ft[15:0];
    pending_frames.push_back(f);
    frames_pushed++;
    if (key != KEY_UP && stick_on) busy_frames++;
  endtask

  // Config writes go in only with nothing in flight.
  task automatic settle();
    while (pending_frames.size() != 0 || in_tvalid || expected_sticks.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    case (idx)
      CFG_CENTER_MODE: cfg_mode      = val[1:0];
      CFG_AREA_CX:     area_x        = val;
      CFG_AREA_CY:     area_y        = val;
      CFG_RADIUS:      radius_reg    = val;
      CFG_ASPECT:      aspect_reg    = val;
      CFG_MAX_AXIS:    max_axis_only = val[0];
      CFG_ENABLE:      stick_on      = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      2:       return int'($urandom_range(30768, 36768));
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_ftime();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 65535;
      2:       return 16384;   // exactly the full-follow point
      3:       return int'($urandom_range(0, 65535));
      default: return int'($urandom_range(0, 4000));
    endcase
  endfunction

  function automatic int nudge(input int v, input int span);
    int n;
    n = v + int'($urandom_range(0, 2 * span)) - span;
    if (n < 0) n = 0;
    if (n > 65535) n = 65535;
    return n;
  endfunction

  // Press, drag for a while, usually release, then a few up frames.
  task automatic add_gesture();
    int x, y, span;
    x = pick_coord();
    y = pick_coord();
    case ($urandom_range(0, 2))
      0:       span = 8;
      1:       span = 300;
      default: span = 6000;
    endcase
    add_frame(KEY_PRESSED, x, y, pick_ftime());
    repeat ($urandom_range(0, 10)) begin
      x = nudge(x, span);
      y = nudge(y, span);
      add_frame(KEY_HELD, x, y, pick_ftime());
    end
    if ($urandom_range(0, 9) < 8) add_frame(KEY_RELEASED, x, y, pick_ftime());
    repeat ($urandom_range(0, 2))
      add_frame(KEY_UP, pick_coord(), pick_coord(), pick_ftime());
  endtask

  function automatic logic [15:0] pick_radius();
    case ($urandom_range(0, 6))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd65535;
      3:       return 16'($urandom_range(1, 65535));
      4:       return 16'($urandom_range(1, 4000));
      default: return 16'($urandom_range(100, 20000));
    endcase
  endfunction

  function automatic logic [15:0] pick_aspect();
    case ($urandom_range(0, 6))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd4096;
      3:       return 16'd65535;
      4:       return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(2048, 8192));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase, phase_busy, phase_pushed;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset config: area center at origin, radius 1.
    add_frame(KEY_PRESSED, 32768, 32768, 0);
    add_frame(KEY_HELD, 65535, 65535, 65535);
    add_frame(KEY_RELEASED, 65535, 0, 0);
    add_frame(KEY_UP, 65535, 65535, 65535);
    add_frame(KEY_HELD, 100, 200, 7);        // held with no press before it
    settle();

    // Max-axis mode around a centered area: equal |dx| and |dy| pick x.
    write_reg(CFG_AREA_CX, 16'd32768);
    write_reg(CFG_AREA_CY, 16'd32768);
    write_reg(CFG_RADIUS, 16'd65535);
    write_reg(CFG_MAX_AXIS, 16'd1);
    add_frame(KEY_PRESSED, 33768, 33768, 100);
    add_frame(KEY_HELD, 31768, 31768, 100);
    add_frame(KEY_HELD, 32768, 34768, 100);
    add_frame(KEY_HELD, 32768, 30768, 100);
    add_frame(KEY_HELD, 0, 65535, 100);
    settle();

    // Spare mode code, zero radius and zero aspect read as one.
    write_reg(CFG_CENTER_MODE, 16'(MODE_SPARE));
    write_reg(CFG_MAX_AXIS, 16'd0);
    write_reg(CFG_RADIUS, 16'd0);
    write_reg(CFG_ASPECT, 16'd0);
    add_frame(KEY_PRESSED, 65535, 0, 0);
    add_frame(KEY_HELD, 1000, 1000, 500);
    settle();

    // Activation point center.
    write_reg(CFG_CENTER_MODE, 16'(MODE_ACT));
    write_reg(CFG_RADIUS, 16'd20000);
    write_reg(CFG_ASPECT, 16'd65535);
    add_frame(KEY_PRESSED, 40000, 20000, 0);
    add_frame(KEY_HELD, 50000, 10000, 900);
    add_frame(KEY_RELEASED, 0, 65535, 900);
    settle();

    // Swipe follow, including a clamped blend and a zero frame time.
    write_reg(CFG_CENTER_MODE, 16'(MODE_SWIPE));
    write_reg(CFG_ASPECT, 16'd2048);
    add_frame(KEY_PRESSED, 30000, 30000, 100);
    add_frame(KEY_HELD, 60000, 60000, 5000);
    add_frame(KEY_HELD, 10000, 5000, 65535);
    add_frame(KEY_HELD, 12000, 6000, 0);
    settle();

    // Disabled stick: every frame reads all zero.
    write_reg(CFG_ENABLE, 16'd0);
    add_frame(KEY_PRESSED, 1234, 4321, 50);
    add_frame(KEY_HELD, 65535, 0, 65535);
    settle();
    write_reg(CFG_ENABLE, 16'd1);

    // Random part: a fresh config per phase, mostly well-formed gestures.
    phase = 0;
    while (frames_pushed < RandomFrames) begin
      settle();
      write_reg(CFG_CENTER_MODE, 16'($urandom_range(0, 3)));
      write_reg(CFG_AREA_CX, ($urandom_range(0, 1) != 0) ? 16'd32768 : 16'($urandom));
      write_reg(CFG_AREA_CY, ($urandom_range(0, 1) != 0) ? 16'd32768 : 16'($urandom));
      write_reg(CFG_RADIUS, pick_radius());
      write_reg(CFG_ASPECT, pick_aspect());
      write_reg(CFG_MAX_AXIS, 16'($urandom_range(0, 1)));
      write_reg(CFG_ENABLE, ($urandom_range(0, 9) != 0) ? 16'd1 : 16'd0);
      burst_mode   = (phase == 2);
      phase_busy   = busy_frames;
      phase_pushed = frames_pushed;
      // disabled phases are cut off by frame count
      while (busy_frames - phase_busy < PhaseFrames &&
             frames_pushed - phase_pushed < 2 * PhaseFrames &&
             frames_pushed < RandomFrames) begin
        if ($urandom_range(0, 99) < 80) begin
          add_gesture();
        end else begin
          repeat ($urandom_range(1, 4))
            add_frame(2'($urandom_range(0, 3)), int'($urandom_range(0, 65535)),
                      int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)));
        end
      end
      phase++;
    end

    settle();
    burst_mode = 1'b0;
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0 && expected_sticks.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ttsm_pkg.sv
rtl/ttsm_mul.sv
rtl/ttsm_iter.sv
rtl/touch_to_thumbstick_mapper_top.sv
tb/tb_top.sv
